[sv/dawl_pkg.sv]
// ----------------------------------------------------------------------------
// dawl_pkg
// shared constants and controller/datapath interface types for the
// direction-aware window low-pass filter
// ----------------------------------------------------------------------------
package dawl_pkg;

    localparam int WINDOW  = 8;
    localparam int PTR_W   = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int DATA_W  = 32;
    localparam int FACT_W  = 17;
    localparam int STEP_W  = DATA_W + 1;
    localparam int MUL_W   = STEP_W + FACT_W + 1;
    localparam int FRAC_W  = 16;
    localparam int IDX_W   = 1;

    localparam logic [FACT_W-1:0] ONE_Q16      = 17'd65536;
    localparam logic [FACT_W-1:0] SMOOTH_RESET = 17'd19661;
    localparam logic [FACT_W-1:0] TREND_RESET  = 17'd52429;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_SMOOTH = 1'b0;
    localparam logic [IDX_W-1:0] REG_TREND  = 1'b1;

    // input op codes
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic push;
        logic clear;
        logic rd_en;
        logic old_cap;
        logic mul_lp;
        logic mul_run;
        logic add;
        logic first_cap;
        logic out_load;
    } dawl_cmd_t;

    typedef struct packed {
        logic will_fill;
    } dawl_status_t;

endpackage

[sv/dawl_ctrl.sv]
// ----------------------------------------------------------------------------
// dawl_ctrl
// sequencer for the window filter: low-pass path, window refilter loop and
// result register handshake
// ----------------------------------------------------------------------------
module dawl_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_op,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  dawl_pkg::dawl_status_t status,
    output dawl_pkg::dawl_cmd_t    cmd
);
    import dawl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LP_MUL,
        ST_LP_ADD,
        ST_RD_OLD,
        ST_RD_NXT,
        ST_RUN_MUL,
        ST_RUN_ADD,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] iter_reg, iter_next;
    logic             m_valid_reg, m_valid_next;
    logic             last_iter;

    assign last_iter = (iter_reg == PTR_W'(WINDOW - 2));
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        iter_next  = iter_reg;
        case (state_reg)
            ST_IDLE: begin
                iter_next = '0;
                if (s_valid) begin
                    if (s_op == OP_CLEAR) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        cmd.push   = 1'b1;
                        state_next = status.will_fill ? ST_RD_OLD : ST_LP_MUL;
                    end
                end
            end
            ST_LP_MUL: begin
                cmd.mul_lp = 1'b1;
                state_next = ST_LP_ADD;
            end
            ST_LP_ADD: begin
                cmd.add    = 1'b1;
                state_next = ST_DONE;
            end
            ST_RD_OLD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_RD_NXT;
            end
            ST_RD_NXT: begin
                cmd.old_cap = 1'b1;
                cmd.rd_en   = 1'b1;
                state_next  = ST_RUN_MUL;
            end
            ST_RUN_MUL: begin
                cmd.mul_run = 1'b1;
                // no fetch past the newest entry
                cmd.rd_en   = !last_iter;
                state_next  = ST_RUN_ADD;
            end
            ST_RUN_ADD: begin
                cmd.add       = 1'b1;
                cmd.first_cap = (iter_reg == '0);
                if (last_iter) begin
                    state_next = ST_DONE;
                end else begin
                    iter_next  = iter_reg + 1'b1;
                    state_next = ST_RUN_MUL;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while still pending");

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken before the first finished");

    a_mul_then_add: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mul_run || cmd.mul_lp) |=> cmd.add)
        else $error("blend product not followed by round stage");

    a_iter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_reg <= PTR_W'(WINDOW - 2))
        else $error("refilter iteration count out of range");

endmodule

[sv/dawl_datapath.sv]
// ----------------------------------------------------------------------------
// dawl_datapath
// sample window, filter state, factor registers and the shared
// multiply / round / saturate blend unit
// ----------------------------------------------------------------------------
module dawl_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dawl_pkg::IDX_W-1:0]          cfg_index,
    input  logic [dawl_pkg::FACT_W-1:0]         cfg_wr_data,
    input  logic signed [dawl_pkg::DATA_W-1:0]  s_sample,
    output logic signed [dawl_pkg::DATA_W-1:0]  m_filtered,
    input  dawl_pkg::dawl_cmd_t                 cmd,
    output dawl_pkg::dawl_status_t              status
);
    import dawl_pkg::*;

    logic signed [DATA_W-1:0] mem [WINDOW];

    logic [PTR_W-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]         fill_reg;
    logic [FACT_W-1:0]        smooth_reg, trend_reg;
    logic signed [DATA_W-1:0] cur_reg, first_reg, pfirst_reg;
    logic signed [DATA_W-1:0] rd_data_reg, prev_new_reg, sample_reg;
    logic signed [DATA_W-1:0] base_reg, filtered_reg;
    logic signed [STEP_W-1:0] last_step_reg;
    logic [1:0]               changes_reg;
    logic signed [MUL_W-1:0]  mul_reg;

    logic [FACT_W-1:0]        low_f, cfg_sat, f_sel;
    logic signed [DATA_W-1:0] a_sel, b_sel;
    logic signed [STEP_W-1:0] step, diff;
    logic signed [FACT_W:0]   f_ext;
    logic signed [MUL_W-1:0]  prod, sum;
    logic signed [MUL_W-FRAC_W-1:0] quo;
    logic signed [DATA_W-1:0] blend_out;
    logic                     flip;
    logic [1:0]               changes_next;
    logic [STEP_W-1:0]        first_diff;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        next_ptr = (p == PTR_W'(WINDOW - 1)) ? '0 : p + 1'b1;
    endfunction

    assign status.will_fill = (fill_reg >= CNT_W'(WINDOW - 1));
    assign m_filtered       = filtered_reg;

    assign cfg_sat    = (cfg_wr_data > ONE_Q16) ? ONE_Q16 : cfg_wr_data;
    assign low_f      = ((ONE_Q16 - smooth_reg) < smooth_reg) ? (ONE_Q16 - smooth_reg)
                                                              : smooth_reg;
    assign first_diff = {first_reg[DATA_W-1], first_reg} - {pfirst_reg[DATA_W-1], pfirst_reg};

    // direction test and factor choice for one refilter step
    always_comb begin
        step = {rd_data_reg[DATA_W-1], rd_data_reg} - {cur_reg[DATA_W-1], cur_reg};
        flip = (step != '0) && (last_step_reg != '0)
            && (step[STEP_W-1] != last_step_reg[STEP_W-1]);
        changes_next = (flip && changes_reg < 2'd2) ? changes_reg + 2'd1 : changes_reg;
        if (cmd.mul_lp) begin
            a_sel = sample_reg;
            b_sel = cur_reg;
            f_sel = smooth_reg;
        end else begin
            a_sel = rd_data_reg;
            if (changes_next < 2'd2 && !flip) begin
                b_sel = cur_reg;
                f_sel = trend_reg;
            end else if (changes_next < 2'd2) begin
                b_sel = prev_new_reg;
                f_sel = smooth_reg;
            end else begin
                b_sel = cur_reg;
                f_sel = low_f;
            end
        end
    end

    // blend(a, b, f) = b + (a - b) * f / 2^16, rounded half up
    always_comb begin
        diff  = {a_sel[DATA_W-1], a_sel} - {b_sel[DATA_W-1], b_sel};
        f_ext = {1'b0, f_sel};
        prod  = diff * f_ext;
        sum   = ({{(MUL_W-DATA_W){base_reg[DATA_W-1]}}, base_reg} <<< FRAC_W)
              + mul_reg + MUL_W'(1 << (FRAC_W - 1));
        quo   = sum[MUL_W-1:FRAC_W];
        if (quo[MUL_W-FRAC_W-1:DATA_W-1] == '0
            || quo[MUL_W-FRAC_W-1:DATA_W-1] == '1) begin
            blend_out = quo[DATA_W-1:0];
        end else if (quo[MUL_W-FRAC_W-1]) begin
            blend_out = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            blend_out = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    // window memory
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[wr_ptr_reg] <= s_sample;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // control-side state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
            cur_reg    <= '0;
            first_reg  <= '0;
            pfirst_reg <= '0;
            smooth_reg <= SMOOTH_RESET;
            trend_reg  <= TREND_RESET;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SMOOTH: smooth_reg <= cfg_sat;
                    REG_TREND:  trend_reg  <= cfg_sat;
                    default: ;
                endcase
            end
            if (cmd.clear) begin
                wr_ptr_reg <= '0;
                fill_reg   <= '0;
                cur_reg    <= '0;
                first_reg  <= '0;
                pfirst_reg <= '0;
            end
            if (cmd.push) begin
                wr_ptr_reg <= next_ptr(wr_ptr_reg);
                if (fill_reg < CNT_W'(WINDOW)) begin
                    fill_reg <= fill_reg + 1'b1;
                end
                // refilter run starts from the saved first value
                if (status.will_fill) begin
                    pfirst_reg <= first_reg;
                    cur_reg    <= first_reg;
                end
            end
            if (cmd.mul_lp) begin
                pfirst_reg <= cur_reg;
                first_reg  <= cur_reg;
            end
            if (cmd.add) begin
                cur_reg <= blend_out;
            end
            if (cmd.first_cap) begin
                first_reg <= blend_out;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            sample_reg    <= s_sample;
            rd_ptr_reg    <= next_ptr(wr_ptr_reg);
            last_step_reg <= first_diff;
            changes_reg   <= 2'd0;
        end
        if (cmd.rd_en) begin
            rd_ptr_reg <= next_ptr(rd_ptr_reg);
        end
        if (cmd.old_cap) begin
            prev_new_reg <= rd_data_reg;
        end
        if (cmd.mul_lp || cmd.mul_run) begin
            mul_reg  <= prod;
            base_reg <= b_sel;
        end
        if (cmd.mul_run) begin
            changes_reg   <= changes_next;
            last_step_reg <= step;
        end
        if (cmd.add) begin
            prev_new_reg <= blend_out;
        end
        if (cmd.out_load) begin
            filtered_reg <= cur_reg;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(WINDOW))
        else $error("window fill count out of range");

    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (cur_reg == '0 && fill_reg == '0))
        else $error("clear did not reset filter state");

endmodule

[sv/direction_aware_window_lowpass.sv]
// ----------------------------------------------------------------------------
// direction_aware_window_lowpass
// direction-aware window low-pass filter on signed Q16.16 samples
// ----------------------------------------------------------------------------
// latency (accept to m_valid) and throughput differ by item: a clear, a push
//   while filling (a low-pass blend) or a push on a full window, whose
//   WINDOW-1 step refilter chain runs through the shared blend unit, each
//   step a multiply, then round and saturate; one item is taken at a time,
//   the next only once the result is loaded into the output register
// reset: aresetn synchronous active low; empties the window, zeroes the filter
//   values, loads the factor reset values; no clearing pass is needed
// ----------------------------------------------------------------------------
module direction_aware_window_lowpass (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [dawl_pkg::IDX_W-1:0]          cfg_index,
    input  logic [dawl_pkg::FACT_W-1:0]         cfg_wr_data,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic signed [dawl_pkg::DATA_W-1:0]  s_sample,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [dawl_pkg::DATA_W-1:0]  m_filtered
);
    import dawl_pkg::*;

    // command and status bundles between sequencer and datapath
    dawl_cmd_t    cmd;
    dawl_status_t status;

    // sequencer: takes one transfer at a time, walks either the low-pass
    // path or the window refilter loop (a clear skips both), then parks the
    // result in the output register
    dawl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: window memory (newest sample written on push, refilter
    // reads oldest to newest), filter state and blend unit
    dawl_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_sample    (s_sample),
        .m_filtered  (m_filtered),
        .cmd         (cmd),
        .status      (status)
    );

    // a result transfer only follows a finished item
    a_out_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.out_load))
        else $error("result shown without a finished item");

    // an accepted push or clear always issues exactly one datapath start
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> $onehot({cmd.push, cmd.clear}))
        else $error("accepted transfer did not start the datapath");

    // nothing is loaded into the result register while an item is taken
    a_no_load_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !cmd.out_load)
        else $error("result load overlaps an input transfer");

endmodule

[bench/direction_aware_window_lowpass_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// direction_aware_window_lowpass_tb
// self-checking bench for the direction-aware window low-pass filter: a
// behavioral filter model predicts every filtered value, a monitor compares
// each result transfer in order, random idle bursts hit both channels
// ----------------------------------------------------------------------------
module direction_aware_window_lowpass_tb;

    import dawl_pkg::*;

    localparam int CLK_HALF = 4;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [IDX_W-1:0]         cfg_index;
    logic [FACT_W-1:0]        cfg_wr_data;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_op;
    logic signed [DATA_W-1:0] s_sample;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_filtered;

    direction_aware_window_lowpass u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_filtered  (m_filtered)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // filter model state, kept in 64 bits so steps and products are exact
    // ------------------------------------------------------------------------
    longint win_mem [WINDOW];
    int     win_fill;
    int     win_head;
    longint cur_val;
    longint run_first;       // first refiltered value of the last run
    longint run_first_prev;  // the one saved the push before
    longint smooth_q16;
    longint trend_q16;

    logic signed [DATA_W-1:0] filtered_q[$];  // filtered values still owed

    int err_count;
    int in_idle_pct;   // chance per transfer of a sender gap
    int out_idle_pct;  // chance per cycle of a receiver stall

    // random sample walk
    longint walk_level;
    longint walk_drift;

    // ------------------------------------------------------------------------
    // model helpers
    // ------------------------------------------------------------------------

    // weighted blend a*f + b*(1-f), round half up, clamp to 32 bits
    function automatic longint mix_q16(input longint a, input longint b,
                                       input longint f);
        longint r;
        r = (a * f + b * (longint'(ONE_Q16) - f) + 32768) >>> 16;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    // register write side: anything above one reads back as one
    function automatic longint clip_factor(input logic [FACT_W-1:0] v);
        return (v > ONE_Q16) ? longint'(ONE_Q16) : longint'(v);
    endfunction

    function automatic logic signed [DATA_W-1:0] predict_filtered(
        input logic op, input logic signed [DATA_W-1:0] smp);
        longint lo_f, prior, acc, last_d, d, v, nxt;
        int     flips;
        int     k;
        bit     turn;
        if (op == OP_CLEAR) begin
            win_fill       = 0;
            win_head       = 0;
            cur_val        = 0;
            run_first      = 0;
            run_first_prev = 0;
            return '0;
        end
        win_head          = (win_head + WINDOW - 1) % WINDOW;
        win_mem[win_head] = longint'(smp);
        if (win_fill < WINDOW) win_fill++;
        if (win_fill < WINDOW) begin
            // still filling: plain exponential low-pass
            run_first_prev = cur_val;
            run_first      = cur_val;
            cur_val        = mix_q16(longint'(smp), cur_val, smooth_q16);
        end else begin
            // full window: refilter oldest to newest from the saved start
            lo_f = (longint'(ONE_Q16) - smooth_q16 < smooth_q16) ?
                   longint'(ONE_Q16) - smooth_q16 : smooth_q16;
            prior          = win_mem[(win_head + WINDOW - 1) % WINDOW];
            acc            = run_first;
            last_d         = run_first - run_first_prev;
            flips          = 0;
            run_first_prev = run_first;
            for (k = WINDOW - 2; k >= 0; k--) begin
                nxt  = win_mem[(win_head + k) % WINDOW];
                d    = nxt - acc;
                turn = (d > 0 && last_d < 0) || (d < 0 && last_d > 0);
                if (turn && flips < 2) flips++;
                if (flips < 2 && !turn)
                    v = mix_q16(nxt, acc, trend_q16);     // direction holds
                else if (flips < 2)
                    v = mix_q16(nxt, prior, smooth_q16);  // first reversal
                else
                    v = mix_q16(nxt, acc, lo_f);          // choppy input
                acc   = v;
                prior = v;
                if (k == WINDOW - 2) run_first = v;
                last_d = d;
            end
            cur_val = acc;
        end
        return cur_val[DATA_W-1:0];
    endfunction

    // mostly a noisy walk with ramps, plus raw words, extremes, zero steps
    function automatic logic signed [DATA_W-1:0] gen_sample();
        if ($urandom_range(0, 15) == 0)
            walk_drift = longint'($urandom_range(0, 1 << 18)) - (1 << 17);
        if ($urandom_range(0, 31) == 0)
            walk_level = longint'($signed($urandom));
        case ($urandom_range(0, 11))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return '0;
                    default: return -32'sd1;
                endcase
            end
            2: return cur_val[DATA_W-1:0];  // step of exactly zero
            3, 4, 5, 6:
                walk_level = walk_level + walk_drift +
                             longint'($urandom_range(0, 4096)) - 2048;
            default:
                walk_level = walk_level +
                             longint'($urandom_range(0, 1 << 20)) - (1 << 19);
        endcase
        if (walk_level > 64'sd2147483647) walk_level = 64'sd2147483647;
        if (walk_level < -64'sd2147483648) walk_level = -64'sd2147483648;
        return walk_level[DATA_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // shared tasks
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        err_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // one input transfer; valid stays up between back-to-back items
    task automatic send_item(input logic op, input logic signed [DATA_W-1:0] smp);
        if ($urandom_range(0, 99) < in_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_op     <= op;
        s_sample <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        filtered_q.push_back(predict_filtered(op, smp));
    endtask

    // drop valid and wait until every owed result has come back
    task automatic wait_results_done();
        s_valid <= 1'b0;
        do @(posedge aclk); while (filtered_q.size() != 0);
    endtask

    // write both factors back to back; block is idle here
    task automatic write_factors(input logic [FACT_W-1:0] smooth_v,
                                 input logic [FACT_W-1:0] trend_v);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_SMOOTH;
        cfg_wr_data <= smooth_v;
        @(posedge aclk);
        cfg_index   <= REG_TREND;
        cfg_wr_data <= trend_v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        smooth_q16 = clip_factor(smooth_v);
        trend_q16  = clip_factor(trend_v);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // clear on empty, fill with extreme words, refilter them, clear when full
    task automatic test_extreme_samples();
        send_item(OP_CLEAR, 32'sh1234_5678);
        send_item(OP_PUSH, 32'sh7FFF_FFFF);
        send_item(OP_PUSH, 32'sh8000_0000);
        send_item(OP_PUSH, 32'sh0000_0000);
        send_item(OP_PUSH, -32'sd1);
        send_item(OP_PUSH, 32'sd1);
        send_item(OP_PUSH, 32'sh0001_0000);
        send_item(OP_PUSH, 32'shFFFF_0000);
        send_item(OP_PUSH, 32'sh7FFF_FFFF);
        send_item(OP_PUSH, 32'sh8000_0000);
        send_item(OP_CLEAR, 32'sh0);
        wait_results_done();
    endtask

    // steady ramp keeps the trend factor, then alternating steps flip it
    task automatic test_direction_runs();
        int i;
        for (i = 0; i < 10; i++)
            send_item(OP_PUSH, i * 32'sh0001_0000);
        for (i = 0; i < 5; i++)
            send_item(OP_PUSH, (i % 2) ? 32'sh0004_0000 : -32'sh0004_0000);
        wait_results_done();
    endtask

    // random traffic over several factor settings, extremes among them
    task automatic test_factor_settings();
        logic [FACT_W-1:0] sm, tr;
        int                ph, i;
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin sm = SMOOTH_RESET; tr = TREND_RESET; end
                1: begin sm = '0;           tr = ONE_Q16;     end
                2: begin sm = ONE_Q16;      tr = '0;          end
                3: begin sm = '1;           tr = '1;          end  // above one
                4: begin sm = 17'd32768;    tr = 17'd32768;   end
                default: begin
                    sm = FACT_W'($urandom_range(0, 65536));
                    tr = FACT_W'($urandom_range(0, 65536));
                end
            endcase
            write_factors(sm, tr);
            // alternate busy phases with calm ones
            in_idle_pct  = (ph % 2) ? 0 : 30;
            out_idle_pct = (ph % 3 == 1) ? 0 : 15;
            for (i = 0; i < 95; i++) begin
                if ($urandom_range(0, 49) == 0)
                    send_item(OP_CLEAR, $urandom);
                else
                    send_item(OP_PUSH, gen_sample());
            end
            wait_results_done();
        end
    endtask

    // full rate both ways, no idling at all
    task automatic test_back_to_back();
        int i;
        in_idle_pct  = 0;
        out_idle_pct = 0;
        write_factors(FACT_W'($urandom_range(0, 65536)),
                      FACT_W'($urandom_range(0, 65536)));
        for (i = 0; i < 50; i++)
            send_item((i == 20) ? OP_CLEAR : OP_PUSH, gen_sample());
        wait_results_done();
    endtask

    // ------------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        logic signed [DATA_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (filtered_q.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer, filtered=%h", m_filtered));
            end else begin
                want = filtered_q.pop_front();
                if (m_filtered !== want)
                    report_mismatch($sformatf("filtered got %h want %h", m_filtered, want));
            end
        end
    end

    // receiver: random stall bursts of random length
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && $urandom_range(0, 99) < out_idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = REG_SMOOTH;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_op         = OP_PUSH;
        s_sample     = '0;
        err_count    = 0;
        in_idle_pct  = 20;
        out_idle_pct = 20;
        walk_level   = 0;
        walk_drift   = 64'sd4096;
        win_fill       = 0;
        win_head       = 0;
        cur_val        = 0;
        run_first      = 0;
        run_first_prev = 0;
        smooth_q16     = longint'(SMOOTH_RESET);
        trend_q16      = longint'(TREND_RESET);
        foreach (win_mem[i]) win_mem[i] = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extreme_samples();
        test_direction_runs();
        test_factor_settings();
        test_back_to_back();

        // catch any stray transfer after the last one owed
        repeat (2 * WINDOW + 8) @(posedge aclk);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[direction_aware_window_lowpass.f]
sv/dawl_pkg.sv
sv/dawl_ctrl.sv
sv/dawl_datapath.sv
sv/direction_aware_window_lowpass.sv
bench/direction_aware_window_lowpass_tb.sv
